// ===== hw/rtl/rssa_pkg.sv =====
// Shared constants and types of the range scan sector averager.
`default_nettype none

package rssa_pkg;

   // Default geometry of one scan.
   localparam int DEF_SECTORS            = 36;
   localparam int DEF_SAMPLES_PER_SECTOR = 21;
   localparam int DEF_LEADING_SKIP       = 6;

   // Field and state widths.
   localparam int RANGE_W   = 16;
   localparam int INDEX_W   = 6;
   localparam int SUM_W     = 21;
   localparam int COUNT_W   = 5;
   localparam int POS_W     = 10;
   localparam int POS_LIMIT = 1023;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Register reset values.
   localparam logic [RANGE_W-1:0] RST_OBSTACLE  = 16'd1000;
   localparam logic [RANGE_W-1:0] RST_EMERGENCY = 16'd500;
   localparam logic [INDEX_W-1:0] RST_FRONT_FIRST = 6'd9;
   localparam logic [INDEX_W-1:0] RST_FRONT_LAST  = 6'd26;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OBSTACLE    = 2'd0,
      CSR_EMERGENCY   = 2'd1,
      CSR_FRONT_FIRST = 2'd2,
      CSR_FRONT_LAST  = 2'd3
   } csr_index_type;

   // Status of the serial divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rssa_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module rssa_divider #(
   parameter int DIVIDEND_W = rssa_pkg::SUM_W,
   parameter int DIVISOR_W  = rssa_pkg::COUNT_W
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [DIVIDEND_W-1:0]       dividend,
   input  wire logic [DIVISOR_W-1:0]        divisor,
   output rssa_pkg::div_status_type         status,
   output logic      [DIVIDEND_W-1:0]       quotient
);

   localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVISOR_W:0]    shifted;
   logic                  ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge      = (shifted >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = ge ? DIVISOR_W'(shifted - {1'b0, div_ff}) : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/range_scan_sector_averager_unit.sv =====
// A sector-closing request gives its response after the 21 bit-serial divider steps,
// the divide state that picks up the quotient, and the finish state.
// Throughput: one request per cycle inside a sector; a closing request holds the input
// off until the divide and finish states are through; an untaken response extends this.
// Reset (synchronous, active high) clears scan position, sums, flags and the response
// valid, and loads the registers with their default values.
`default_nettype none

module range_scan_sector_averager_unit #(
   parameter int SECTORS            = rssa_pkg::DEF_SECTORS,
   parameter int SAMPLES_PER_SECTOR = rssa_pkg::DEF_SAMPLES_PER_SECTOR,
   parameter int LEADING_SKIP       = rssa_pkg::DEF_LEADING_SKIP
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [rssa_pkg::RANGE_W-1:0]    req_tdata,   // [15:0] range_mm
   input  wire logic                            req_tuser,   // [0] scan_start
   // response channel
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [23:0]                          rsp_tdata,   // [5:0] sector_index,
                                                             // [21:6] sector_mean, rest 0
   output logic                                 rsp_tlast,   // scan_done
   output logic [1:0]                           rsp_tuser,   // [0] path_blocked,
                                                             // [1] emergency
   // configuration port
   input  wire logic                            csr_we,
   input  wire logic [rssa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rssa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int RANGE_W = rssa_pkg::RANGE_W;
   localparam int INDEX_W = rssa_pkg::INDEX_W;
   localparam int SUM_W   = rssa_pkg::SUM_W;
   localparam int COUNT_W = rssa_pkg::COUNT_W;
   localparam int POS_W   = rssa_pkg::POS_W;

   localparam int SCAN_END = LEADING_SKIP + SECTORS * SAMPLES_PER_SECTOR;
   localparam int STOP_INT = (SCAN_END < rssa_pkg::POS_LIMIT) ? SCAN_END : rssa_pkg::POS_LIMIT;
   localparam logic [POS_W-1:0] STOP_POS = POS_W'(STOP_INT);
   localparam logic [POS_W:0]   SKIP_POS = (POS_W + 1)'(LEADING_SKIP);
   localparam int OFF_W = (SAMPLES_PER_SECTOR > 2) ? $clog2(SAMPLES_PER_SECTOR) : 1;
   localparam logic [OFF_W-1:0]   OFF_LAST = OFF_W'(SAMPLES_PER_SECTOR - 1);
   localparam logic [INDEX_W-1:0] IDX_LAST = INDEX_W'(SECTORS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // registers
   state_type            state_ff, state_in;
   logic [RANGE_W-1:0]   obstacle_ff, obstacle_in;
   logic [RANGE_W-1:0]   emergency_ff, emergency_in;
   logic [INDEX_W-1:0]   front_first_ff, front_first_in;
   logic [INDEX_W-1:0]   front_last_ff, front_last_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                 blocked_ff, blocked_in;
   logic                 emerg_ff, emerg_in;
   logic [INDEX_W-1:0]   held_idx_ff, held_idx_in;
   logic                 few_ff, few_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [23:0]          rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [1:0]           rsp_user_ff, rsp_user_in;

   // request side
   logic                 req_fire;
   logic                 start;
   logic [RANGE_W-1:0]   range_mm;
   logic [POS_W-1:0]     p;
   logic [OFF_W-1:0]     off_cur;
   logic [INDEX_W-1:0]   idx_cur;
   logic [SUM_W-1:0]     sum_cur, sum_eff;
   logic [COUNT_W-1:0]   cnt_cur, cnt_eff;
   logic                 active, counted, qualify, sector_end;

   // divider and finish
   logic                     div_start;
   rssa_pkg::div_status_type div_status;
   logic [SUM_W-1:0]         quotient;
   logic [RANGE_W-1:0]       mean;
   logic                     front, blocked_new, emerg_new, done;
   logic                     slot_free;

   rssa_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (COUNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_eff),
      .divisor  (cnt_eff),
      .status   (div_status),
      .quotient (quotient)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign start      = req_tuser;
   assign range_mm   = req_tdata;

   // scan start clears the scan state before the sample is taken
   always_comb begin
      p        = start ? '0 : pos_ff;
      off_cur  = start ? '0 : off_ff;
      idx_cur  = start ? '0 : idx_ff;
      sum_cur  = start ? '0 : sum_ff;
      cnt_cur  = start ? '0 : cnt_ff;
      active   = (p < STOP_POS);
      counted  = active && ({1'b0, p} >= SKIP_POS);
      qualify  = (range_mm != '0) && (range_mm < obstacle_ff);
      sum_eff  = qualify ? SUM_W'(sum_cur + SUM_W'(range_mm)) : sum_cur;
      cnt_eff  = qualify ? COUNT_W'(cnt_cur + 1'b1) : cnt_cur;
      sector_end = counted && (off_cur == OFF_LAST);
   end

   // finish: mean, front window check, sticky flags
   always_comb begin
      mean        = few_ff ? '0 : quotient[RANGE_W-1:0];
      front       = (held_idx_ff >= front_first_ff) && (held_idx_ff <= front_last_ff)
                    && (mean != '0);
      blocked_new = blocked_ff || (front && (mean < obstacle_ff));
      emerg_new   = emerg_ff || (front && (mean < emergency_ff));
      done        = (held_idx_ff == IDX_LAST);
      slot_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in       = state_ff;
      obstacle_in    = obstacle_ff;
      emergency_in   = emergency_ff;
      front_first_in = front_first_ff;
      front_last_in  = front_last_ff;
      pos_in         = pos_ff;
      off_in         = off_ff;
      idx_in         = idx_ff;
      sum_in         = sum_ff;
      cnt_in         = cnt_ff;
      blocked_in     = blocked_ff;
      emerg_in       = emerg_ff;
      held_idx_in    = held_idx_ff;
      few_in         = few_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_user_in    = rsp_user_ff;
      div_start      = 1'b0;

      if (csr_we) begin
         case (rssa_pkg::csr_index_type'(csr_index))
            rssa_pkg::CSR_OBSTACLE:    obstacle_in    = csr_wdata[RANGE_W-1:0];
            rssa_pkg::CSR_EMERGENCY:   emergency_in   = csr_wdata[RANGE_W-1:0];
            rssa_pkg::CSR_FRONT_FIRST: front_first_in = csr_wdata[INDEX_W-1:0];
            rssa_pkg::CSR_FRONT_LAST:  front_last_in  = csr_wdata[INDEX_W-1:0];
            default: ;
         endcase
      end

      // drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (start) begin
                  pos_in     = '0;
                  off_in     = '0;
                  idx_in     = '0;
                  sum_in     = '0;
                  cnt_in     = '0;
                  blocked_in = 1'b0;
                  emerg_in   = 1'b0;
               end
               if (active) begin
                  pos_in = POS_W'(p + 1'b1);
               end
               if (counted) begin
                  if (sector_end) begin
                     // close the sector: hand sum and count to the divider
                     div_start   = 1'b1;
                     held_idx_in = idx_cur;
                     few_in      = (cnt_eff < COUNT_W'(2));
                     sum_in      = '0;
                     cnt_in      = '0;
                     off_in      = '0;
                     idx_in      = INDEX_W'(idx_cur + 1'b1);
                     state_in    = ST_DIVIDE;
                  end else begin
                     sum_in = sum_eff;
                     cnt_in = cnt_eff;
                     off_in = OFF_W'(off_cur + 1'b1);
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (slot_free) begin
               blocked_in   = blocked_new;
               emerg_in     = emerg_new;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, mean, held_idx_ff};
               rsp_last_in  = done;
               rsp_user_in  = {done && emerg_new, done && blocked_new};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         obstacle_ff    <= rssa_pkg::RST_OBSTACLE;
         emergency_ff   <= rssa_pkg::RST_EMERGENCY;
         front_first_ff <= rssa_pkg::RST_FRONT_FIRST;
         front_last_ff  <= rssa_pkg::RST_FRONT_LAST;
         pos_ff         <= '0;
         off_ff         <= '0;
         idx_ff         <= '0;
         sum_ff         <= '0;
         cnt_ff         <= '0;
         blocked_ff     <= 1'b0;
         emerg_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         obstacle_ff    <= obstacle_in;
         emergency_ff   <= emergency_in;
         front_first_ff <= front_first_in;
         front_last_ff  <= front_last_in;
         pos_ff         <= pos_in;
         off_ff         <= off_in;
         idx_ff         <= idx_in;
         sum_ff         <= sum_in;
         cnt_ff         <= cnt_in;
         blocked_ff     <= blocked_in;
         emerg_ff       <= emerg_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      held_idx_ff <= held_idx_in;
      few_ff      <= few_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // no request may enter while the divider works on a sector
   a_no_req_while_dividing: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !req_tready)
      else $error("request accepted while divider busy");

   // divider completion only arrives while waiting for it
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide state");

   // end of scan comes only with the last sector
   a_last_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tdata[INDEX_W-1:0] == IDX_LAST))
      else $error("scan done on a sector other than the last");

   // path and emergency flags stay low outside end of scan
   a_flags_at_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tuser == 2'b00))
      else $error("status flags set before end of scan");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the range scan sector averager: stream driver, checker, predictor.
`timescale 1ns / 100ps

module testbench;

   // Geometry of one scan; the block is built with the same values.
   localparam int SECTORS            = rssa_pkg::DEF_SECTORS;
   localparam int SAMPLES_PER_SECTOR = rssa_pkg::DEF_SAMPLES_PER_SECTOR;
   localparam int LEADING_SKIP       = rssa_pkg::DEF_LEADING_SKIP;
   localparam int SCAN_END           = LEADING_SKIP + SECTORS * SAMPLES_PER_SECTOR;

   localparam int ITEM_TARGET   = 1600;    // counted requests before the stimulus stops
   localparam int SETTLE_CYCLES = 30;      // drain wait once every report is in
   localparam int END_CYCLES    = 40;
   localparam int HOLD_AFTER    = 200;     // requests taken before the long receiver hold-off
   localparam int HOLD_CYCLES   = 600;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SHOWN_ERRORS  = 10;

   // One entry of the stimulus plan: a sample request, a register write, or a drain pause.
   typedef enum logic [1:0] {STEP_SAMPLE, STEP_WRITE, STEP_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type           kind;
      logic [15:0]             range_mm;
      logic                    scan_start;
      int unsigned             gap;
      rssa_pkg::csr_index_type index;
      logic [15:0]             value;
   } scan_step_type;

   // Content profile of one sector in a planned scan.
   typedef enum logic [1:0] {
      SECTOR_CLEAR, SECTOR_LONE, SECTOR_NEAR, SECTOR_MIXED
   } sector_mix_type;

   // Expected sector report, one per closing request.
   typedef struct packed {
      logic [5:0]  sector;
      logic [15:0] mean;
      logic        done;
      logic        blocked;
      logic        emergency;
   } sector_report_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [15:0]             req_tdata  = '0;      // [15:0] range_mm
   logic                    req_tuser  = 1'b0;    // [0] scan_start
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [23:0]             rsp_tdata;            // [5:0] sector_index, [21:6] sector_mean
   logic                    rsp_tlast;            // scan_done
   logic [1:0]              rsp_tuser;            // [0] path_blocked, [1] emergency
   logic                    csr_we     = 1'b0;
   rssa_pkg::csr_index_type csr_index  = rssa_pkg::CSR_OBSTACLE;
   logic [15:0]             csr_wdata  = '0;

   // Stimulus plan and the reports still owed by the block.
   scan_step_type     scan_plan[$];
   sector_report_type expected_sectors[$];

   // Planning view of the registers, used to shape sample values.
   int unsigned plan_obstacle;
   int unsigned plan_emergency;
   int unsigned plan_first;
   int unsigned plan_last;
   bit          quiet_stretch;
   int unsigned planned;
   int unsigned ignored_planned;

   // Predictor state and its copy of the registers.
   logic [9:0]  pred_position;
   logic [20:0] pred_sum;
   logic [4:0]  pred_count;
   logic        pred_blocked;
   logic        pred_emergency;
   logic [15:0] cfg_obstacle;
   logic [15:0] cfg_emergency;
   logic [5:0]  cfg_front_first;
   logic [5:0]  cfg_front_last;

   // Driver, receiver and bookkeeping.
   int unsigned gap_left;
   int unsigned settle_left;
   bit          draining;
   int unsigned stall_left;
   logic        holding;
   int unsigned hold_left;
   bit          hold_used;
   int unsigned requests_taken;
   int unsigned results_seen;
   int unsigned scans_closed;
   int unsigned blocked_reports;
   int unsigned emergency_reports;
   int unsigned mismatches;
   int unsigned cycle_count;

   range_scan_sector_averager_unit #(
      .SECTORS            (SECTORS),
      .SAMPLES_PER_SECTOR (SAMPLES_PER_SECTOR),
      .LEADING_SKIP       (LEADING_SKIP)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Fold one accepted request into the predicted scan state; queue a report when it
   // closes a sector.
   task automatic fold_range_sample(input logic [15:0] range_mm, input logic scan_start);
      int unsigned       p;
      int unsigned       q;
      int unsigned       sector;
      int unsigned       offset;
      int unsigned       mean;
      sector_report_type report;
      if (scan_start) begin
         pred_position  = '0;
         pred_sum       = '0;
         pred_count     = '0;
         pred_blocked   = 1'b0;
         pred_emergency = 1'b0;
      end
      p = pred_position;
      // Past the last sector, or at the position ceiling: drop the sample.
      if (p >= SCAN_END || p >= rssa_pkg::POS_LIMIT)
         return;
      pred_position = 10'(p + 1);
      if (p < LEADING_SKIP)
         return;
      q      = p - LEADING_SKIP;
      sector = q / SAMPLES_PER_SECTOR;
      offset = q % SAMPLES_PER_SECTOR;
      if (range_mm != 16'd0 && range_mm < cfg_obstacle) begin
         pred_sum   = pred_sum + 21'(range_mm);
         pred_count = pred_count + 5'd1;
      end
      if (offset != SAMPLES_PER_SECTOR - 1)
         return;
      mean = (pred_count >= 5'd2) ? pred_sum / pred_count : 0;
      mean = mean & 32'hFFFF;
      pred_sum   = '0;
      pred_count = '0;
      // Front sectors with a nonzero mean set the sticky scan flags.
      if (sector >= cfg_front_first && sector <= cfg_front_last && mean > 0) begin
         if (mean < cfg_obstacle)
            pred_blocked = 1'b1;
         if (mean < cfg_emergency)
            pred_emergency = 1'b1;
      end
      report.sector    = 6'(sector);
      report.mean      = 16'(mean);
      report.done      = (sector == SECTORS - 1);
      report.blocked   = report.done && pred_blocked;
      report.emergency = report.done && pred_emergency;
      expected_sectors.push_back(report);
   endtask

   // Pick a range value that qualifies under the planned obstacle distance, or one that
   // mostly does not.
   function automatic logic [15:0] draw_range(input bit qualify);
      int unsigned r;
      int unsigned near_top;
      r = $urandom_range(0, 99);
      if (qualify && plan_obstacle > 1) begin
         near_top = (plan_emergency < plan_obstacle) ? plan_emergency : plan_obstacle;
         if (r < 30 && near_top > 1)
            return 16'($urandom_range(1, near_top - 1));
         if (r < 40)
            return 16'(plan_obstacle - 1);
         return 16'($urandom_range(1, plan_obstacle - 1));
      end
      if (r < 30)
         return 16'd0;
      if (r < 45)
         return 16'(plan_obstacle);
      if (r < 55)
         return 16'hFFFF;
      if (r < 80)
         return 16'($urandom_range(plan_obstacle, 65535));
      return 16'($urandom_range(0, 65535));
   endfunction

   // Append one sample request with a random idle gap after it.
   task automatic add_sample(input logic [15:0] range_mm, input logic scan_start,
                             input bit counted);
      scan_step_type step;
      int unsigned   r;
      r               = $urandom_range(0, 99);
      step.kind       = STEP_SAMPLE;
      step.range_mm   = range_mm;
      step.scan_start = scan_start;
      step.index      = rssa_pkg::CSR_OBSTACLE;
      step.value      = '0;
      if (quiet_stretch || r < 70)
         step.gap = 0;
      else if (r < 93)
         step.gap = $urandom_range(1, 3);
      else
         step.gap = $urandom_range(8, 40);
      scan_plan.push_back(step);
      if (counted)
         planned++;
      else
         ignored_planned++;
   endtask

   task automatic add_write(input rssa_pkg::csr_index_type index, input int unsigned value);
      scan_step_type step;
      step.kind       = STEP_WRITE;
      step.range_mm   = '0;
      step.scan_start = 1'b0;
      step.gap        = 0;
      step.index      = index;
      step.value      = 16'(value);
      scan_plan.push_back(step);
   endtask

   // Drain the block, then load a new register set. The first two phases take the
   // extremes; later ones are random.
   task automatic plan_settings(input int phase);
      scan_step_type step;
      step.kind       = STEP_DRAIN;
      step.range_mm   = '0;
      step.scan_start = 1'b0;
      step.gap        = 0;
      step.index      = rssa_pkg::CSR_OBSTACLE;
      step.value      = '0;
      scan_plan.push_back(step);
      case (phase)
         0: begin
            // Everything but zero and full scale qualifies; emergency flag disabled.
            plan_obstacle  = 65535;
            plan_emergency = 0;
            plan_first     = 0;
            plan_last      = 63;
         end
         1: begin
            // Nothing qualifies and the forward window is empty.
            plan_obstacle  = 0;
            plan_emergency = 65535;
            plan_first     = 63;
            plan_last      = 0;
         end
         default: begin
            plan_obstacle  = $urandom_range(300, 4000);
            plan_emergency = $urandom_range(0, plan_obstacle + 500);
            plan_first     = $urandom_range(0, 40);
            plan_last      = $urandom_range(0, 45);
         end
      endcase
      add_write(rssa_pkg::CSR_OBSTACLE, plan_obstacle);
      add_write(rssa_pkg::CSR_EMERGENCY, plan_emergency);
      add_write(rssa_pkg::CSR_FRONT_FIRST, plan_first);
      add_write(rssa_pkg::CSR_FRONT_LAST, plan_last);
   endtask

   // A whole scan with a random profile per sector, then a few samples past its end.
   task automatic plan_full_scan();
      sector_mix_type mix;
      int unsigned    hit;
      int unsigned    r;
      bit             qualify;
      mix = SECTOR_MIXED;
      hit = 0;
      for (int p = 0; p < SCAN_END; p++) begin
         if (p < LEADING_SKIP) begin
            qualify = $urandom_range(0, 1);
         end else begin
            if ((p - LEADING_SKIP) % SAMPLES_PER_SECTOR == 0) begin
               r   = $urandom_range(0, 99);
               mix = (r < 30) ? SECTOR_CLEAR : (r < 45) ? SECTOR_LONE :
                     (r < 75) ? SECTOR_NEAR : SECTOR_MIXED;
               hit = $urandom_range(0, SAMPLES_PER_SECTOR - 1);
               quiet_stretch = ($urandom_range(0, 3) == 0);
            end
            case (mix)
               SECTOR_CLEAR: qualify = ($urandom_range(0, 19) == 0);
               SECTOR_LONE:  qualify = ((p - LEADING_SKIP) % SAMPLES_PER_SECTOR == hit);
               SECTOR_NEAR:  qualify = ($urandom_range(0, 9) != 0);
               default:      qualify = $urandom_range(0, 1);
            endcase
         end
         add_sample(draw_range(qualify), p == 0, 1'b1);
      end
      // Samples past the last sector produce nothing until the next scan start.
      quiet_stretch = 1'b0;
      repeat ($urandom_range(5, 25))
         add_sample(draw_range($urandom_range(0, 1)), 1'b0, 1'b0);
   endtask

   // A scan cut short by the next scan start; its open sector is discarded.
   task automatic plan_partial_scan();
      int unsigned length;
      length        = $urandom_range(20, 100);
      quiet_stretch = ($urandom_range(0, 1) == 0);
      for (int i = 0; i < length; i++)
         add_sample(draw_range($urandom_range(0, 1)), i == 0, 1'b1);
   endtask

   // Driver: offer planned requests, apply register writes while idle, and predict each
   // accepted request at the edge that takes it.
   always @(posedge clock) begin : drive_requests
      scan_step_type step;
      logic          offer;
      logic          write_now;
      if (reset) begin
         req_tvalid      <= 1'b0;
         req_tdata       <= '0;
         req_tuser       <= 1'b0;
         csr_we          <= 1'b0;
         csr_index       <= rssa_pkg::CSR_OBSTACLE;
         csr_wdata       <= '0;
         pred_position   = '0;
         pred_sum        = '0;
         pred_count      = '0;
         pred_blocked    = 1'b0;
         pred_emergency  = 1'b0;
         cfg_obstacle    = rssa_pkg::RST_OBSTACLE;
         cfg_emergency   = rssa_pkg::RST_EMERGENCY;
         cfg_front_first = rssa_pkg::RST_FRONT_FIRST;
         cfg_front_last  = rssa_pkg::RST_FRONT_LAST;
         gap_left        = 0;
         settle_left     = 0;
         draining        = 1'b0;
      end else begin
         offer     = req_tvalid;
         write_now = 1'b0;
         if (req_tvalid && req_tready) begin
            fold_range_sample(req_tdata, req_tuser);
            requests_taken <= requests_taken + 1;
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (draining) begin
               // Hold until every report is in and the divider has had time to finish.
               if (expected_sectors.size() != 0)
                  settle_left = SETTLE_CYCLES;
               else if (settle_left > 0)
                  settle_left--;
               else
                  draining = 1'b0;
            end else if (scan_plan.size() != 0) begin
               step = scan_plan.pop_front();
               case (step.kind)
                  STEP_SAMPLE: begin
                     offer = 1'b1;
                     req_tdata <= step.range_mm;
                     req_tuser <= step.scan_start;
                     gap_left  = step.gap;
                  end
                  STEP_WRITE: begin
                     write_now = 1'b1;
                     csr_index <= step.index;
                     csr_wdata <= step.value;
                     case (step.index)
                        rssa_pkg::CSR_OBSTACLE:    cfg_obstacle    = step.value;
                        rssa_pkg::CSR_EMERGENCY:   cfg_emergency   = step.value;
                        rssa_pkg::CSR_FRONT_FIRST: cfg_front_first = step.value[5:0];
                        rssa_pkg::CSR_FRONT_LAST:  cfg_front_last  = step.value[5:0];
                        default: ;
                     endcase
                  end
                  STEP_DRAIN: begin
                     draining    = 1'b1;
                     settle_left = SETTLE_CYCLES;
                  end
                  default: ;
               endcase
            end
         end
         req_tvalid <= offer;
         csr_we     <= write_now;
      end
   end

   // Long receiver hold-off, once, while the driver keeps offering requests.
   always @(posedge clock) begin
      if (reset) begin
         holding   <= 1'b0;
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (holding) begin
         if (hold_left == 0)
            holding <= 1'b0;
         else
            hold_left <= hold_left - 1;
      end else if (!hold_used && requests_taken >= HOLD_AFTER) begin
         holding   <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end
   end

   // Checker: compare each accepted report with the oldest prediction, and stall the
   // response side at random.
   always @(posedge clock) begin : check_responses
      sector_report_type want;
      logic              ready_next;
      int unsigned       r;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_sectors.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_ERRORS)
                  $display("ERROR: unexpected report: sector %0d mean %0d done %0b flags %b",
                           rsp_tdata[5:0], rsp_tdata[21:6], rsp_tlast, rsp_tuser);
            end else begin
               want = expected_sectors.pop_front();
               if (rsp_tdata[5:0] != want.sector || rsp_tdata[21:6] != want.mean ||
                   rsp_tdata[23:22] != 2'b00 || rsp_tlast != want.done ||
                   rsp_tuser[0] != want.blocked || rsp_tuser[1] != want.emergency) begin
                  mismatches++;
                  if (mismatches <= SHOWN_ERRORS) begin
                     $display("ERROR: report mismatch: expected sector %0d mean %0d done %0b %s",
                              want.sector, want.mean, want.done, "");
                     $display("       expected blocked %0b emergency %0b",
                              want.blocked, want.emergency);
                     $display("       got sector %0d mean %0d done %0b blocked %0b",
                              rsp_tdata[5:0], rsp_tdata[21:6], rsp_tlast, rsp_tuser[0]);
                     $display("       got emergency %0b pad %b",
                              rsp_tuser[1], rsp_tdata[23:22]);
                  end
               end
               if (want.done) begin
                  scans_closed++;
                  blocked_reports   += want.blocked;
                  emergency_reports += want.emergency;
               end
            end
         end
         // Mostly ready; short stalls often, long ones now and then.
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               ready_next = 1'b1;
            end else if (r < 93) begin
               ready_next = 1'b0;
               stall_left = $urandom_range(0, 2);
            end else begin
               ready_next = 1'b0;
               stall_left = $urandom_range(10, 40);
            end
         end
         rsp_tready <= ready_next && !holding;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, expected_sectors.size());
         $display("FAIL range_scan_sector_averager_unit");
         $finish;
      end
   end

   initial begin
      logic [15:0] opening;
      int          phase;
      requests_taken    = 0;
      results_seen      = 0;
      scans_closed      = 0;
      blocked_reports   = 0;
      emergency_reports = 0;
      mismatches        = 0;
      cycle_count       = 0;
      planned           = 0;
      ignored_planned   = 0;
      quiet_stretch     = 1'b0;
      plan_obstacle     = rssa_pkg::RST_OBSTACLE;
      plan_emergency    = rssa_pkg::RST_EMERGENCY;
      plan_first        = rssa_pkg::RST_FRONT_FIRST;
      plan_last         = rssa_pkg::RST_FRONT_LAST;

      // Opening sector with reset registers and no scan start: the first request after
      // reset counts as position zero. Cover zero, full scale, both sides of the obstacle
      // distance and alternating bit patterns.
      for (int i = 0; i < LEADING_SKIP + SAMPLES_PER_SECTOR; i++) begin
         case (i)
            0:       opening = 16'hFFFF;
            1:       opening = 16'd0;
            6:       opening = 16'd0;
            7:       opening = 16'd1;
            8:       opening = 16'd999;
            9:       opening = 16'd1000;
            10:      opening = 16'hFFFF;
            11:      opening = 16'd500;
            12:      opening = 16'd499;
            13:      opening = 16'h5555;
            14:      opening = 16'hAAAA;
            15:      opening = 16'h8000;
            default: opening = 16'(i * 37);
         endcase
         add_sample(opening, 1'b0, 1'b1);
      end
      // Scan start in the middle of nowhere, followed by an open sector that gets dropped.
      add_sample(16'hFFFF, 1'b1, 1'b1);
      add_sample(16'd2, 1'b0, 1'b1);
      add_sample(16'd998, 1'b0, 1'b1);

      // Alternate whole scans and aborted ones, each under a fresh register set.
      phase = 0;
      while (planned < ITEM_TARGET) begin
         plan_settings(phase);
         if (phase % 2 == 0)
            plan_full_scan();
         else
            plan_partial_scan();
         phase++;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait for the plan to run out and every report to arrive, then let the block settle.
      while (!(scan_plan.size() == 0 && !req_tvalid && !draining &&
               expected_sectors.size() == 0))
         @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      $display("Run covered %0d requests (%0d past scan end) over %0d register phases.",
               requests_taken, ignored_planned, phase);
      $display("Checked %0d sector reports, %0d closed scans (%0d blocked, %0d emergency).",
               results_seen, scans_closed, blocked_reports, emergency_reports);
      if (mismatches == 0 && expected_sectors.size() == 0)
         $display("PASS range_scan_sector_averager_unit");
      else
         $display("FAIL range_scan_sector_averager_unit");
      $finish;
   end

endmodule
